/* src/pfs_pkg.sv */
// Shared types and field widths for the per-channel frame time statistics block.
package pfs_pkg;

    localparam int COMMAND_W  = 2;
    localparam int CHANNEL_W  = 3;
    localparam int DURATION_W = 24;
    localparam int TICK_W     = 32;
    localparam int FRAME_W    = 32;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_BEGIN = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_END   = 2'd2
    } t_cmd;

endpackage

/* src/pfs_cmd_if.sv */
// Command channel: begin frame, add sample and end frame transactions.
interface pfs_cmd_if
    import pfs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [COMMAND_W-1:0]  command;
    logic [CHANNEL_W-1:0]  channel;
    logic [DURATION_W-1:0] duration;

    modport source (output valid, output command, output channel, output duration,
                    input ready);
    modport sink   (input valid, input command, input channel, input duration,
                    output ready);
endinterface

/* src/pfs_stats_if.sv */
// Statistics channel: one transaction per used channel at the end of a frame.
interface pfs_stats_if
    import pfs_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] channel_id;
    logic [TICK_W-1:0]    current_total;
    logic [TICK_W-1:0]    window_average;
    logic [TICK_W-1:0]    window_peak;
    logic [FRAME_W-1:0]   frame_number;
    logic                 last;

    modport source (output valid, output channel_id, output current_total,
                    output window_average, output window_peak, output frame_number,
                    output last, input ready);
    modport sink   (input valid, input channel_id, input current_total,
                    input window_average, input window_peak, input frame_number,
                    input last, output ready);
endinterface

/* src/pfs_div.sv */
// Divider by a constant: one digit per cycle, each digit by reciprocal multiplication.
module pfs_div
    import pfs_pkg::*;
#(
    parameter int DIVIDEND_W = 38,
    parameter int DIVISOR    = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int DIG_W   = 16;
    localparam int NUM_DIG = (DIVIDEND_W + DIG_W - 1) / DIG_W;
    localparam int PAD_W   = NUM_DIG * DIG_W;
    localparam int REM_W   = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
    localparam int X_W     = REM_W + DIG_W;
    localparam int SHIFT   = X_W + REM_W;
    localparam int RCP_W   = X_W + 1;
    localparam int PROD_W  = X_W + RCP_W;
    localparam int CNT_W   = $clog2(NUM_DIG + 1);

    // Rounded-up reciprocal. The partial dividend stays below DIVISOR * 2**DIG_W, which
    // fits in X_W bits, and for such values the product's top bits are the exact quotient.
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [REM_W-1:0]      r_rem;
    logic [PAD_W-1:0]      r_num;
    logic [PAD_W-1:0]      r_quo;
    logic [X_W-1:0]        n_x;
    logic [PROD_W-1:0]     n_prod;
    logic [DIG_W-1:0]      n_q;
    logic [X_W-1:0]        n_back;
    logic [X_W-1:0]        n_rem;

    // The remainder so far and the next dividend digit form the partial dividend.
    always_comb begin
        n_x    = {r_rem, r_num[PAD_W-1 -: DIG_W]};
        n_prod = PROD_W'(n_x) * PROD_W'(RECIP);
        n_q    = n_prod[SHIFT +: DIG_W];
        n_back = X_W'(n_q) * X_W'(DIVISOR);
        n_rem  = n_x - n_back;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_num  <= PAD_W'(i_dividend);
                r_quo  <= '0;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(NUM_DIG);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= r_num << DIG_W;
                r_quo <= (r_quo << DIG_W) | PAD_W'(n_q);
                r_rem <= n_rem[REM_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[DIVIDEND_W-1:0];

endmodule

/* src/per_channel_frame_time_window_stats.sv */
// Top level of the per-channel frame time statistics monitor.
//
// Commands arrive on i_cmd as transactions. A begin frame transaction clears every
// channel's tick accumulator, an add sample transaction adds a duration to one channel
// (saturating at the all-ones value) and marks it used, and an end frame transaction
// reports on every used channel in ascending order through o_stats.
// Begin frame, add sample and unknown commands leave i_cmd ready, so i_cmd can take
// one such transaction per cycle. An end frame holds i_cmd off while it runs: a scan
// over the channels, and per used channel a write of its total into the ring memory, a
// walk over the ring memory (one read per cycle through its read port, then a fold of
// the last read and a hand-over of the sum), a division for the mean (one 16-bit digit
// per cycle by reciprocal multiplication), and a load of the result register.
// Results sit in an output register; when o_stats stalls, the next channel's walk and
// division still run and only the load waits for the register to empty. The final
// result carries last; i_cmd is ready again once the scan has passed the channels left.
// After reset the history memory is cleared one entry per cycle, all NUM_CHANNELS times
// 2**ceil(log2(HISTORY_DEPTH)) entries, during which i_cmd is held off.
module per_channel_frame_time_window_stats
    import pfs_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int NUM_CHANNELS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfs_cmd_if.sink     i_cmd,
    pfs_stats_if.source o_stats
);

    localparam int SLOT_W    = $clog2(HISTORY_DEPTH);
    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ADDR_W    = CH_W + SLOT_W;
    localparam int MEM_DEPTH = NUM_CHANNELS * (2 ** SLOT_W);
    localparam int SUM_W     = TICK_W + SLOT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_WALK,
        S_DIV,
        S_OUT
    } t_state;

    t_state                 r_state;
    logic [ADDR_W-1:0]      r_clr;
    logic [TICK_W-1:0]      r_acc [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_used;
    logic [SLOT_W-1:0]      r_slot;
    logic [FRAME_W-1:0]     r_frame;
    logic [CH_W:0]          r_walk;
    logic [SLOT_W:0]        r_idx;
    logic                   r_rd_vld;
    logic [SUM_W-1:0]       r_sum;
    logic [TICK_W-1:0]      r_peak;
    logic [TICK_W-1:0]      r_total;
    logic [TICK_W-1:0]      r_avg;

    logic                   r_o_valid;
    logic [CHANNEL_W-1:0]   r_o_channel;
    logic [TICK_W-1:0]      r_o_total;
    logic [TICK_W-1:0]      r_o_avg;
    logic [TICK_W-1:0]      r_o_peak;
    logic [FRAME_W-1:0]     r_o_frame;
    logic                   r_o_last;

    // History ring memory: one row of 2**SLOT_W entries per channel.
    logic [TICK_W-1:0]      r_ring [MEM_DEPTH];
    logic [TICK_W-1:0]      r_rd_data;

    logic                   in_acc;
    logic [CH_W-1:0]        add_idx;
    logic                   add_ok;
    logic [CH_W-1:0]        walk_idx;
    logic [CH_W-1:0]        acc_idx;
    logic [TICK_W-1:0]      acc_rd;
    logic [TICK_W:0]        n_acc_sum;
    logic [TICK_W-1:0]      n_acc_sat;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [TICK_W-1:0]      mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;
    logic                   walk_end;
    logic                   more_used;
    logic                   out_load;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quo;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign in_acc      = i_cmd.valid && i_cmd.ready;

    // Channel numbers at or beyond NUM_CHANNELS are dropped by add sample.
    assign add_idx  = CH_W'(i_cmd.channel);
    assign add_ok   = (32'(i_cmd.channel) < NUM_CHANNELS);
    assign walk_idx = r_walk[CH_W-1:0];

    // The accumulators have a single read port, shared by add sample and the ring write.
    assign acc_idx   = (r_state == S_IDLE) ? add_idx : walk_idx;
    assign acc_rd    = r_acc[acc_idx];
    assign n_acc_sum = {1'b0, acc_rd} + (TICK_W+1)'(i_cmd.duration);
    assign n_acc_sat = n_acc_sum[TICK_W] ? '1 : n_acc_sum[TICK_W-1:0];

    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr : {walk_idx, r_slot};
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : acc_rd;
    assign mem_raddr = {walk_idx, r_idx[SLOT_W-1:0]};

    // The walk is finished once every read has been issued and the last one folded in.
    assign walk_end = (r_idx == (SLOT_W+1)'(HISTORY_DEPTH)) && !r_rd_vld;

    // A result is loaded when the output register is empty or being emptied.
    assign out_load = (r_state == S_OUT) && (!r_o_valid || o_stats.ready);

    // A result is the last of its frame when no used channel follows it.
    always_comb begin
        more_used = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (r_used[c] && (c > int'(r_walk))) begin
                more_used = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_ring[mem_raddr];
    end

    pfs_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR    (HISTORY_DEPTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_WALK) && walk_end),
        .i_dividend (r_sum),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_used    <= '0;
            r_slot    <= '0;
            r_frame   <= '0;
            r_walk    <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_acc[c] <= '0;
            end
        end else begin
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_stats.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(MEM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_cmd.command)
                            CMD_BEGIN: begin
                                for (int c = 0; c < NUM_CHANNELS; c++) begin
                                    r_acc[c] <= '0;
                                end
                            end
                            CMD_ADD: begin
                                if (add_ok) begin
                                    r_acc[add_idx]  <= n_acc_sat;
                                    r_used[add_idx] <= 1'b1;
                                end
                            end
                            CMD_END: begin
                                r_walk  <= '0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_walk == (CH_W+1)'(NUM_CHANNELS)) begin
                        if (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) begin
                            r_slot <= '0;
                        end else begin
                            r_slot <= r_slot + 1'b1;
                        end
                        r_frame <= r_frame + 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_used[walk_idx]) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_walk <= r_walk + 1'b1;
                    end
                end
                S_WRITE: begin
                    // The frame total lands in the ring now; the walk reads it back later.
                    r_total  <= acc_rd;
                    r_idx    <= '0;
                    r_rd_vld <= 1'b0;
                    r_sum    <= '0;
                    r_peak   <= '0;
                    r_state  <= S_WALK;
                end
                S_WALK: begin
                    if (r_rd_vld) begin
                        r_sum <= r_sum + SUM_W'(r_rd_data);
                        if (r_rd_data > r_peak) begin
                            r_peak <= r_rd_data;
                        end
                    end
                    if (r_idx != (SLOT_W+1)'(HISTORY_DEPTH)) begin
                        r_idx    <= r_idx + 1'b1;
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (walk_end) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_avg   <= div_quo[TICK_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_o_channel <= CHANNEL_W'(r_walk);
                        r_o_total   <= r_total;
                        r_o_avg     <= r_avg;
                        r_o_peak    <= r_peak;
                        r_o_frame   <= r_frame;
                        r_o_last    <= !more_used;
                        r_walk      <= r_walk + 1'b1;
                        r_state     <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stats.valid          = r_o_valid;
    assign o_stats.channel_id     = r_o_channel;
    assign o_stats.current_total  = r_o_total;
    assign o_stats.window_average = r_o_avg;
    assign o_stats.window_peak    = r_o_peak;
    assign o_stats.frame_number   = r_o_frame;
    assign o_stats.last           = r_o_last;

endmodule
